// ===== src/h263sc_pkg.sv =====
// ----------------------------------------------------------------------------
// h263sc_pkg: shared types and constants of the start code packet splitter
// byte word, result word, event record and status codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package h263sc_pkg;

	localparam logic [15:0] MIN_PACKET   = 16'd4;
	localparam logic [15:0] MAX_RESET    = 16'd1400;
	localparam logic [7:0]  CODE_BIT     = 8'h80;
	localparam logic [7:0]  PIC_MASK     = 8'hFC;
	localparam logic [15:0] PREV_RESET   = 16'hFFFF;

	localparam logic [1:0]  ST_OK        = 2'd0;
	localparam logic [1:0]  ST_NO_CODE   = 2'd1;
	localparam logic [1:0]  ST_NO_PIC    = 2'd2;

	localparam int          QUEUE_DEPTH  = 4;
	localparam int          QUEUE_AW     = $clog2(QUEUE_DEPTH);
	localparam int          QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} item_t;

	typedef struct packed {
		logic [15:0] packet_length;
		logic        last_packet;
		logic [1:0]  status;
	} result_t;

	// what one byte produced: an optional cut and an optional frame-end word
	typedef struct packed {
		logic        cut_v;
		logic [15:0] cut_len;
		logic        fin_v;
		logic [15:0] fin_len;
		logic [1:0]  fin_status;
	} event_t;

endpackage

// ===== src/h263sc_front.sv =====
// ----------------------------------------------------------------------------
// h263sc_front: byte classifier
// scans for start codes, tracks the packet and pushes cut/frame-end events
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h263sc_front import h263sc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	input  logic        q_full,
	output logic        push,
	output event_t      push_ev
);

	logic [15:0] max_size_q;
	logic [15:0] bytes_q;
	logic [15:0] code_off_q;
	logic [15:0] prev_q;
	logic        pic_seen_q;
	logic        failed_q;

	logic [15:0] max_eff;
	logic        code;
	logic        pic2;
	logic [15:0] off_upd;
	logic        cut_due;
	logic        emit1;
	logic [15:0] p2;
	logic [15:0] off2;
	logic        failed2;
	logic [15:0] bytes2;
	logic        emit2;
	logic [15:0] bytes3;
	logic        failed3;
	logic        accept;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;

	always_comb begin
		max_eff = (max_size_q < MIN_PACKET) ? MIN_PACKET : max_size_q;
		code    = (prev_q == 16'd0) && (item.data_byte >= CODE_BIT);
		pic2    = pic_seen_q || (code && ((item.data_byte & PIC_MASK) == CODE_BIT));

		// latest start code in the window of the current packet
		off_upd = code_off_q;
		if (!failed_q && code && (bytes_q >= 16'd3) &&
				((bytes_q - 16'd2) <= (max_eff - 16'd2))) begin
			off_upd = bytes_q - 16'd2;
		end

		cut_due = !failed_q && (bytes_q >= max_eff);
		emit1   = cut_due && (off_upd != 16'd0);
		p2      = emit1 ? (bytes_q - off_upd) : bytes_q;
		off2    = emit1 ? 16'd0 : off_upd;
		failed2 = failed_q || (cut_due && !emit1);
		bytes2  = failed2 ? bytes_q : (p2 + 16'd1);

		// frame end with a full packet: one more cut attempt
		emit2   = item.end_of_frame && !failed2 && (bytes2 >= max_eff) && (off2 != 16'd0);
		bytes3  = emit2 ? (bytes2 - off2) : bytes2;
		failed3 = failed2 || (item.end_of_frame && !failed2 && (bytes3 >= max_eff));

		push_ev.cut_v      = emit1 || emit2;
		push_ev.cut_len    = emit1 ? off_upd : off2;
		push_ev.fin_v      = item.end_of_frame;
		push_ev.fin_len    = failed3 ? 16'd0 : bytes3;
		push_ev.fin_status = !pic2 ? ST_NO_PIC : (failed3 ? ST_NO_CODE : ST_OK);
	end

	assign push = accept && (push_ev.cut_v || push_ev.fin_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= MAX_RESET;
		end else if (cfg_wr_en) begin
			max_size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q    <= '0;
			code_off_q <= '0;
			prev_q     <= PREV_RESET;
			pic_seen_q <= 1'b0;
			failed_q   <= 1'b0;
		end else if (accept) begin
			if (item.end_of_frame) begin
				bytes_q    <= '0;
				code_off_q <= '0;
				prev_q     <= PREV_RESET;
				pic_seen_q <= 1'b0;
				failed_q   <= 1'b0;
			end else begin
				bytes_q    <= bytes2;
				code_off_q <= off2;
				prev_q     <= {prev_q[7:0], item.data_byte};
				pic_seen_q <= pic2;
				failed_q   <= failed2;
			end
		end
	end

endmodule

// ===== src/h263sc_queue.sv =====
// ----------------------------------------------------------------------------
// h263sc_queue: event queue
// small fifo between the classifier and the result serializer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h263sc_queue import h263sc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t push_ev,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output event_t head
);

	event_t               slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_CW-1:0]  count_q;
	logic                 do_pop;

	assign full      = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/h263sc_back.sv =====
// ----------------------------------------------------------------------------
// h263sc_back: result serializer
// turns each event into one or two result words behind an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h263sc_back import h263sc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    ev_avail,
	input  event_t  ev,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    out_valid_q;
	result_t out_word_q;
	logic    hold_valid_q;
	result_t hold_word_q;
	logic    load;
	result_t cut_word;
	result_t fin_word;

	assign result_valid = out_valid_q;
	assign result       = out_word_q;
	assign load         = !out_valid_q || result_ready;
	assign pop          = load && !hold_valid_q && ev_avail;

	always_comb begin
		cut_word.packet_length = ev.cut_len;
		cut_word.last_packet   = 1'b0;
		cut_word.status        = ST_OK;
		fin_word.packet_length = ev.fin_len;
		fin_word.last_packet   = 1'b1;
		fin_word.status        = ev.fin_status;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (hold_valid_q) begin
				out_word_q <= hold_word_q;
			end else if (ev.cut_v) begin
				out_word_q <= cut_word;
			end else begin
				out_word_q <= fin_word;
			end
		end
		if (pop && ev.cut_v && ev.fin_v) begin
			hold_word_q <= fin_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= hold_valid_q || ev_avail;
			hold_valid_q <= pop && ev.cut_v && ev.fin_v;
		end
	end

endmodule

// ===== src/h263_start_code_packet_splitter_top.sv =====
// ----------------------------------------------------------------------------
// h263_start_code_packet_splitter_top: start code packet splitter
// cuts a coded video frame into packets at start code boundaries
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid/item_ready/item): one frame byte per word, with
//   end_of_frame set on the frame's last byte
//   result channel (result_valid/result_ready/result): one word per closed
//   packet (length, last-packet mark, status); the frame-end word carries
//   last_packet = 1 and the frame status
//   cfg_wr_en/cfg_wr_data: writes max_packet_size, taken at once; write it
//   only while no byte is in flight
// timing
//   one byte accepted every cycle while the queue has room; a byte's event
//   is registered in the event queue and then in the output register, which
//   raises result_valid; a byte that yields two words sends its cut word,
//   then its frame-end word from a hold register; the rate is set by the
//   combinational classifier; a four-entry event queue precedes the output register
// stalls and reset
//   a stalled receiver fills the event queue, after which item_ready drops
//   for every byte until an entry frees up
//   reset empties the queue and output, clears frame state and loads 1400
//   as the maximum packet size
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h263_start_code_packet_splitter_top import h263sc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result
);

	// classifier to queue
	logic   push;
	event_t push_ev;
	logic   q_full;

	// queue to serializer
	logic   q_not_empty;
	logic   q_pop;
	event_t q_head;

	// front: start code scan, packet tracking, cut decisions
	h263sc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.q_full      (q_full),
		.push        (push),
		.push_ev     (push_ev)
	);

	// decoupling queue of per-byte events
	h263sc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ev   (push_ev),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// back: one result word per cycle into the output register while the receiver is ready
	h263sc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_avail     (q_not_empty),
		.ev           (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== src/h263sc_checker.sv =====
// ----------------------------------------------------------------------------
// h263sc_checker: port checks for the start code packet splitter
// properties on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h263sc_checker import h263sc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input result_t     result
);

	// stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// mid-frame cuts are always ok
	a_cut_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_packet |-> result.status == ST_OK)
		else $error("non-final word with error status");

	// a cut never closes an empty packet
	a_cut_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_packet |-> result.packet_length != 16'd0)
		else $error("zero-length cut");

	// failed frame reports no tail
	a_fail_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_packet && result.status == ST_NO_CODE
		|-> result.packet_length == 16'd0)
		else $error("failed frame with tail length");

	// only three status codes exist
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status == ST_OK || result.status == ST_NO_CODE ||
			result.status == ST_NO_PIC)
		else $error("undefined status code");

endmodule

bind h263_start_code_packet_splitter_top h263sc_checker u_h263sc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
